>>> rtl/core/approx_grid_point_dedup_assert.svh
// ----------------------------------------------------------------------------
// approx_grid_point_dedup assertion macros
// concurrent checks on the rising clock edge, off while reset is high
// ----------------------------------------------------------------------------
`ifndef APPROX_GRID_POINT_DEDUP_ASSERT_SVH
`define APPROX_GRID_POINT_DEDUP_ASSERT_SVH

`ifndef SYNTHESIS

`define AGPD_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("agpd check failed");

`define AGPD_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("agpd check failed");

`define AGPD_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("agpd check failed");

`else

`define AGPD_ASSERT(label, expr)
`define AGPD_IMPLIES(label, ante, cons)
`define AGPD_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/agpd_pkg.sv
// ----------------------------------------------------------------------------
// agpd_pkg
// payload types, register codes and fixed constants of the grid point dedup
// ----------------------------------------------------------------------------
package agpd_pkg;

   localparam int ENTRY_INDEX_W = 13;
   localparam int TOL_W         = 7;
   localparam int LIMIT_W       = 13;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 13;

   localparam logic [TOL_W-1:0]   TOL_RESET   = 7'd4;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
   localparam logic [7:0]         BYTE_TOP    = 8'hFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_TOLERANCE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_LIMIT     = 4'd1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } agpd_state_type;

   typedef struct packed {
      logic        start_of_set;
      logic [47:0] ambient_maps_01;
      logic [47:0] ambient_maps_23;
      logic [47:0] directed_maps_01;
      logic [47:0] directed_maps_23;
      logic [31:0] style_bytes;
      logic [7:0]  latitude;
      logic [7:0]  longitude;
   } req_payload_type;

   typedef struct packed {
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic                     was_appended;
      logic                     was_dropped;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
   } csr_payload_type;

endpackage

>>> rtl/core/agpd_stream_if.sv
// ----------------------------------------------------------------------------
// agpd_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface agpd_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (
      output valid,
      output payload,
      input  ready
   );

   modport sink (
      input  valid,
      input  payload,
      output ready
   );

endinterface

>>> rtl/core/approx_grid_point_dedup.sv
// Scan: a hit ends the scan at the first matching entry j, a miss after all n stored
// entries; the result waits for a free response slot, and one point is taken at a time.
// Scan rate: set by the single table read port, which is scanned one entry per cycle.
// Reset: synchronous, active high; empties the table count and restores the registers
// (tolerance 4, limit 4096); table contents are not cleared, entries past the count unread.
// ----------------------------------------------------------------------------
// approx_grid_point_dedup
// sequential scan of a point table for the first approximate match, append below the entry limit on miss
// ----------------------------------------------------------------------------
`include "approx_grid_point_dedup_assert.svh"

module approx_grid_point_dedup
   import agpd_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int LIGHT_MAPS  = 4
) (
   input  logic          clock,
   input  logic          reset,
   agpd_stream_if.sink   req,
   agpd_stream_if.source rsp,
   agpd_stream_if.sink   csr
);

   localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int COL_W   = 24 * LIGHT_MAPS;
   localparam int STY_W   = 8 * LIGHT_MAPS;
   localparam int ENTRY_W = 2 * COL_W + STY_W + 16;
   localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(TABLE_DEPTH);

   agpd_state_type     state_ff, state_in;
   req_payload_type    item_ff, item_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [TOL_W-1:0]   tol_ff, tol_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               hit;
   logic               cmp_hit;
   logic               scan_done;
   logic               slot_free;
   logic               finish;
   logic               issue;
   logic               can_append;
   logic               append;
   logic               rd_en;
   logic               wr_en;
   logic [LIM_W-1:0]   limit_l;
   logic [LIM_W-1:0]   eff_limit;
   logic [95:0]        ambient_all;
   logic [95:0]        directed_all;
   logic [ENTRY_W-1:0] probe;
   logic [ENTRY_W-1:0] rd_data;

   // probe layout: longitude, latitude, styles, directed colors, ambient colors
   assign ambient_all  = {item_ff.ambient_maps_23, item_ff.ambient_maps_01};
   assign directed_all = {item_ff.directed_maps_23, item_ff.directed_maps_01};
   assign probe = {item_ff.longitude, item_ff.latitude, item_ff.style_bytes[STY_W-1:0],
                   directed_all[COL_W-1:0], ambient_all[COL_W-1:0]};

   agpd_table_ram #(
      .DEPTH  (TABLE_DEPTH),
      .WIDTH  (ENTRY_W),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (probe),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   agpd_match #(
      .LIGHT_MAPS (LIGHT_MAPS),
      .ENTRY_W    (ENTRY_W)
   ) u_match (
      .probe     (probe),
      .entry     (rd_data),
      .tolerance (tol_ff),
      .hit       (hit)
   );

   assign req_xfer   = req.valid && req.ready;
   assign cmp_hit    = cmp_valid_ff && hit;
   assign scan_done  = cmp_hit || (rd_addr_ff >= count_ff);
   assign slot_free  = !rsp_valid_ff || rsp.ready;
   assign finish     = (state_ff == ST_SCAN) && scan_done && slot_free;
   assign issue      = (state_ff == ST_SCAN) && !scan_done;
   assign limit_l    = LIM_W'(limit_ff);
   assign eff_limit  = (limit_l < DEPTH_L) ? limit_l : DEPTH_L;
   assign can_append = LIM_W'(count_ff) < eff_limit;
   assign append     = finish && !cmp_hit && can_append;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req.ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_SCAN: begin
            rd_en = issue;
            wr_en = append;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   assign csr.ready   = 1'b1;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // datapath and register next values
   always_comb begin
      item_in      = item_ff;
      count_in     = count_ff;
      rd_addr_in   = rd_addr_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      tol_in       = tol_ff;
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (req_xfer) begin
         item_in    = req.payload;
         rd_addr_in = '0;
         if (req.payload.start_of_set) begin
            count_in = '0;
         end
      end

      if (issue) begin
         rd_addr_in   = rd_addr_ff + CNT_W'(1);
         cmp_idx_in   = rd_addr_ff;
         cmp_valid_in = 1'b1;
      end else if ((state_ff == ST_SCAN) && scan_done && !slot_free) begin
         cmp_valid_in = cmp_valid_ff;
      end

      if (append) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.entry_index  = cmp_hit ? ENTRY_INDEX_W'(cmp_idx_ff)
                                            : ENTRY_INDEX_W'(count_ff);
         rsp_data_in.was_appended = !cmp_hit && can_append;
         rsp_data_in.was_dropped  = !cmp_hit && !can_append;
      end

      if (csr.valid) begin
         unique case (csr.payload.reg_index)
            CSR_MATCH_TOLERANCE: tol_in = csr.payload.reg_data[TOL_W-1:0];
            CSR_ENTRY_LIMIT:     limit_in = csr.payload.reg_data[LIMIT_W-1:0];
            default: begin
               tol_in = tol_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_addr_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         tol_ff       <= TOL_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_addr_ff   <= rd_addr_in;
         cmp_valid_ff <= cmp_valid_in;
         tol_ff       <= tol_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      cmp_idx_ff  <= cmp_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   `AGPD_ASSERT(a_count_in_depth, LIM_W'(count_ff) <= DEPTH_L)
   `AGPD_ASSERT(a_no_read_on_write, !(rd_en && wr_en))
   `AGPD_IMPLIES(a_cmp_below_count, cmp_valid_ff, cmp_idx_ff < count_ff)
   `AGPD_NEXT(a_append_grows, append, count_ff == CNT_W'($past(count_ff) + 1'b1))
   `AGPD_ASSERT(a_flags_exclusive, !(rsp_valid_ff && rsp_data_ff.was_appended && rsp_data_ff.was_dropped))

endmodule

>>> rtl/core/agpd_table_ram.sv
// ----------------------------------------------------------------------------
// agpd_table_ram
// point table storage, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module agpd_table_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 240,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/agpd_match.sv
// ----------------------------------------------------------------------------
// agpd_match
// approximate compare of a probe point against one stored table entry
// ----------------------------------------------------------------------------
module agpd_match
   import agpd_pkg::*;
#(
   parameter int LIGHT_MAPS = 4,
   parameter int ENTRY_W    = 56 * LIGHT_MAPS + 16
) (
   input  logic [ENTRY_W-1:0] probe,
   input  logic [ENTRY_W-1:0] entry,
   input  logic [TOL_W-1:0]   tolerance,
   output logic               hit
);

   localparam int COL_W       = 24 * LIGHT_MAPS;
   localparam int COLOR_BYTES = 6 * LIGHT_MAPS;
   localparam int STY_LO      = 2 * COL_W;
   localparam int DIR_LO      = STY_LO + 8 * LIGHT_MAPS;

   function automatic logic [7:0] byte_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [7:0] tol8;

   assign tol8 = {1'b0, tolerance};

   always_comb begin
      logic [7:0] dd;
      hit = 1'b1;
      dd  = '0;
      for (int i = 0; i < COLOR_BYTES; i++) begin
         if (byte_diff(probe[8*i +: 8], entry[8*i +: 8]) > tol8) begin
            hit = 1'b0;
         end
      end
      for (int k = 0; k < LIGHT_MAPS; k++) begin
         if (probe[STY_LO + 8*k +: 8] != entry[STY_LO + 8*k +: 8]) begin
            hit = 1'b0;
         end
      end
      // latitude and longitude wrap around the byte range
      for (int d = 0; d < 2; d++) begin
         dd = byte_diff(probe[DIR_LO + 8*d +: 8], entry[DIR_LO + 8*d +: 8]);
         if (!(dd <= tol8 || dd >= (BYTE_TOP - tol8))) begin
            hit = 1'b0;
         end
      end
   end

endmodule
